@@ sv/slcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slcd_pkg
// shared codes and reset value for the sync / length / checksum deframer
// ----------------------------------------------------------------------------
package slcd_pkg;

	// result kinds
	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_REPORT  = 1'b1;

	// frame end status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_BAD_SUM   = 2'd1;
	localparam logic [1:0] STATUS_TOO_SHORT = 2'd2;
	localparam logic [1:0] STATUS_TOO_LONG  = 2'd3;

	// register map
	localparam logic REG_SYNC_BYTE = 1'b0;

	localparam logic [7:0] SYNC_RESET = 8'h93;

	// sync, length high, length low
	localparam int HEADER_BYTES = 3;

	// smallest legal length field: command plus checksum
	localparam logic [15:0] MIN_LEN = 16'd2;

	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [7:0] cmd;
		logic [10:0] plen;
		logic [1:0] status;
	} result_t;

endpackage

@@ sv/sync_length_checksum_deframer_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_checksum_deframer_top
// byte stream deframer: sync hunt, 16-bit length, command, payload, checksum
// ----------------------------------------------------------------------------
// usage
//   input channel: rx_byte with in_valid / in_ready, one byte per transaction
//   output channel: result_kind, payload_byte, command_id, payload_length,
//   frame_status with out_valid / out_ready, zero or one transaction per byte
//   every payload byte is forwarded as a kind 0 transaction; the checksum byte
//   produces a kind 1 frame end report, as does a bad length field (status 2
//   for length under 2, status 3 for length over MAX_LEN, frame dropped)
//   the checksum is the 8-bit sum of every frame byte before it, sync included
// timing
//   one byte per cycle sustained while the receiver keeps up; a byte goes
//   into the input register when accepted and its result is then loaded
//   into the result register, which drives the outputs; the rate is set
//   by the state update between those two registers
// reset and stall
//   arst_n clears the parser to sync hunting and sync_byte to 0x93
//   a stalled receiver holds the result register; one more byte waits in the
//   input register, after which in_ready drops until the result is taken
// configuration
//   apb register 0 (byte address 0): sync_byte, used by the next sync hunt
// ----------------------------------------------------------------------------
module sync_length_checksum_deframer_top #(
	parameter int MAX_LEN = 1026
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte input
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  rx_byte,
	// results
	output logic        out_valid,
	input  logic        out_ready,
	output logic        result_kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  command_id,
	output logic [10:0] payload_length,
	output logic [1:0]  frame_status,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import slcd_pkg::*;

	// byte counter reaches length + 2 at the checksum byte
	localparam int CNT_W = $clog2(MAX_LEN + 3);
	localparam logic [CNT_W-1:0] CNT_HUNT   = CNT_W'(0);
	localparam logic [CNT_W-1:0] CNT_LEN_HI = CNT_W'(1);
	localparam logic [CNT_W-1:0] CNT_LEN_LO = CNT_W'(2);
	localparam logic [CNT_W-1:0] CNT_CMD    = CNT_W'(HEADER_BYTES);
	localparam logic [16:0] MAX_LEN_V = 17'(MAX_LEN);

	// configuration register
	logic [7:0] sync_byte_q;

	// parser state
	logic [CNT_W-1:0] byte_count_q, byte_count_d;
	logic [15:0]      frame_length_q, frame_length_d;
	logic [7:0]       command_q, command_d;
	logic [7:0]       sum_q, sum_d;

	// input register
	logic       valid_s1;
	logic [7:0] byte_s1;

	// result register
	logic    valid_s2;
	result_t res_s2;

	logic    advance;
	logic    res_valid;
	result_t res;
	logic [15:0] len_full;
	logic [7:0]  sum_add;
	logic [16:0] frame_end;

	// apb: always ready, single register decoded on the word address bit
	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_SYNC_BYTE) ? {24'd0, sync_byte_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sync_byte_q <= SYNC_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_SYNC_BYTE) begin
			sync_byte_q <= pwdata[7:0];
		end
	end

	// the input register moves on whenever the result register is free or
	// being emptied this cycle, so a stall backs up by one byte only
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	// parse step for the byte held in the input register
	assign len_full  = {frame_length_q[15:8], byte_s1};
	assign sum_add   = sum_q + byte_s1;
	assign frame_end = {1'b0, frame_length_q} + 17'd2;

	always_comb begin
		byte_count_d   = byte_count_q;
		frame_length_d = frame_length_q;
		command_d      = command_q;
		sum_d          = sum_q;
		res_valid      = 1'b0;
		res.kind       = KIND_REPORT;
		res.data       = 8'd0;
		res.cmd        = 8'd0;
		res.plen       = 11'd0;
		res.status     = STATUS_OK;

		if (byte_count_q == CNT_HUNT) begin
			if (byte_s1 == sync_byte_q) begin
				sum_d        = byte_s1;
				byte_count_d = CNT_LEN_HI;
			end
		end else if (byte_count_q == CNT_LEN_HI) begin
			frame_length_d = {byte_s1, 8'd0};
			sum_d          = sum_add;
			byte_count_d   = CNT_LEN_LO;
		end else if (byte_count_q == CNT_LEN_LO) begin
			if (len_full < MIN_LEN || {1'b0, len_full} > MAX_LEN_V) begin
				// bad length: report at once and go back to hunting
				res_valid      = 1'b1;
				res.status     = (len_full < MIN_LEN) ? STATUS_TOO_SHORT : STATUS_TOO_LONG;
				byte_count_d   = CNT_HUNT;
				frame_length_d = 16'd0;
				command_d      = 8'd0;
				sum_d          = 8'd0;
			end else begin
				frame_length_d = len_full;
				sum_d          = sum_add;
				byte_count_d   = CNT_CMD;
			end
		end else if (byte_count_q == CNT_CMD) begin
			command_d    = byte_s1;
			sum_d        = sum_add;
			byte_count_d = byte_count_q + CNT_W'(1);
		end else if (17'(byte_count_q) < frame_end) begin
			// payload byte, forwarded as it arrives
			sum_d        = sum_add;
			byte_count_d = byte_count_q + CNT_W'(1);
			res_valid    = 1'b1;
			res.kind     = KIND_PAYLOAD;
			res.data     = byte_s1;
			res.cmd      = command_q;
			res.plen     = 11'(frame_length_q - MIN_LEN);
		end else begin
			// checksum byte closes the frame
			res_valid      = 1'b1;
			res.cmd        = command_q;
			res.plen       = 11'(frame_length_q - MIN_LEN);
			res.status     = (byte_s1 == sum_q) ? STATUS_OK : STATUS_BAD_SUM;
			byte_count_d   = CNT_HUNT;
			frame_length_d = 16'd0;
			command_d      = 8'd0;
			sum_d          = 8'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q   <= CNT_HUNT;
			frame_length_q <= 16'd0;
			command_q      <= 8'd0;
			sum_q          <= 8'd0;
		end else if (advance) begin
			byte_count_q   <= byte_count_d;
			frame_length_q <= frame_length_d;
			command_q      <= command_d;
			sum_q          <= sum_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance && res_valid) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res_valid) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = valid_s2;
	assign result_kind    = res_s2.kind;
	assign payload_byte   = res_s2.data;
	assign command_id     = res_s2.cmd;
	assign payload_length = res_s2.plen;
	assign frame_status   = res_s2.status;

	// hunting always starts from a cleared frame
	a_hunt_clear: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q == CNT_HUNT |-> sum_q == 8'd0 && frame_length_q == 16'd0
			&& command_q == 8'd0)
		else $error("hunt state not cleared");

	// inside a frame the counter never runs past the checksum position
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q > CNT_CMD |-> 17'(byte_count_q) <= frame_end)
		else $error("byte counter past frame end");

	// forwarded payload bytes always carry ok status
	a_payload_status: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.kind == KIND_PAYLOAD |-> res_s2.status == STATUS_OK)
		else $error("payload byte with non-ok status");

	// length error reports carry no command and no length
	a_len_err_fields: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.status == STATUS_TOO_SHORT || res_s2.status == STATUS_TOO_LONG)
		|-> res_s2.cmd == 8'd0 && res_s2.plen == 11'd0 && res_s2.kind == KIND_REPORT)
		else $error("length error report with stale fields");

	// input side only backs up behind a stalled, full result register
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> valid_s1 && valid_s2 && !out_ready)
		else $error("input stalled without output backpressure");

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the sync / length / checksum byte deframer
// ----------------------------------------------------------------------------
// short directed table for the header corner cases: dropped noise, the reset
// sync value, both length errors, an empty payload, a sync value inside a frame
// then random frames, mostly well formed, mixed with bad checksums, length
// errors and noise
// every accepted byte runs through the predictor, output transactions are
// matched in order against it
// sync register rewritten between phases, idling of both channels varies
// ----------------------------------------------------------------------------
module tb_top;
	import slcd_pkg::*;

	localparam int CLK_PERIOD    = 4;
	localparam int RESET_CYCLES  = 7;
	localparam int DF_MAX_LEN    = 1026;
	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT   = 500000;

	// byte addresses of register index 0 and of an unused index 1
	localparam logic [2:0] SYNC_ADDR  = {REG_SYNC_BYTE, 2'b00};
	localparam logic [2:0] SPARE_ADDR = 3'd4;

	// one byte queued for the input channel; typed rows carry their own result
	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic       hold;
		result_t    res;
	} rx_item_t;

	typedef struct packed {
		logic [7:0] b;
		logic       typed;
		logic [1:0] status;
	} dir_row_t;

	// directed table: byte, typed report flag, typed report status
	localparam dir_row_t [0:24] DIRECTED = '{
		'{8'h00, 1'b0, STATUS_OK},        // noise while hunting, dropped
		'{8'h93, 1'b0, STATUS_OK},        // reset sync value
		'{8'h00, 1'b0, STATUS_OK},
		'{8'h01, 1'b1, STATUS_TOO_SHORT}, // length 1
		'{8'h93, 1'b0, STATUS_OK},
		'{8'hff, 1'b0, STATUS_OK},
		'{8'hff, 1'b1, STATUS_TOO_LONG},  // largest length field
		'{8'h93, 1'b0, STATUS_OK},
		'{8'h04, 1'b0, STATUS_OK},
		'{8'h03, 1'b1, STATUS_TOO_LONG},  // one over the limit
		'{8'h93, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, STATUS_OK},
		'{8'h00, 1'b1, STATUS_TOO_SHORT}, // length 0
		'{8'h93, 1'b0, STATUS_OK},        // command only, no payload
		'{8'h00, 1'b0, STATUS_OK},
		'{8'h02, 1'b0, STATUS_OK},
		'{8'hab, 1'b0, STATUS_OK},
		'{8'h40, 1'b0, STATUS_OK},        // good checksum
		'{8'h93, 1'b0, STATUS_OK},        // sync value as command and payload
		'{8'h00, 1'b0, STATUS_OK},
		'{8'h04, 1'b0, STATUS_OK},
		'{8'h93, 1'b0, STATUS_OK},
		'{8'h93, 1'b0, STATUS_OK},
		'{8'hff, 1'b0, STATUS_OK},
		'{8'h00, 1'b0, STATUS_OK}         // bad checksum
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        result_kind;
	logic [7:0]  payload_byte;
	logic [7:0]  command_id;
	logic [10:0] payload_length;
	logic [1:0]  frame_status;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [2:0]  paddr = 3'd0;
	logic [31:0] pwdata = 32'd0;
	logic [31:0] prdata;
	logic        pready;

	// predictor state and its copy of the sync register
	logic [10:0] p_count;
	logic [15:0] p_len;
	logic [7:0]  p_cmd;
	logic [7:0]  p_sum;
	logic [7:0]  p_sync;

	rx_item_t byte_q[$];
	result_t  pending_results[$];

	int tx_idle = 0;
	int rx_idle = 0;
	bit hold_next = 1'b0;
	int frame_bytes = 0;
	int fails = 0;
	int cycles = 0;
	int n_bytes = 0;
	int n_payload = 0;
	int n_report = 0;
	int status_seen [4] = '{0, 0, 0, 0};

	sync_length_checksum_deframer_top #(
		.MAX_LEN(DF_MAX_LEN)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_kind(result_kind),
		.payload_byte(payload_byte),
		.command_id(command_id),
		.payload_length(payload_length),
		.frame_status(frame_status),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// back to sync hunting
	task automatic parser_hunt();
		p_count = '0;
		p_len   = '0;
		p_cmd   = '0;
		p_sum   = '0;
	endtask

	// advance the predictor by one byte; has is set when a result is due
	task automatic deframe_step(input logic [7:0] b, output bit has, output result_t r);
		has = 1'b0;
		r   = '0;
		if (p_count == 0) begin
			if (b == p_sync) begin
				p_sum   = b;
				p_count = 11'd1;
			end
		end else if (p_count == 1) begin
			p_len   = {b, 8'h00};
			p_sum   = p_sum + b;
			p_count = 11'd2;
		end else if (p_count == 2) begin
			p_len = p_len + b;
			p_sum = p_sum + b;
			if (p_len < MIN_LEN) begin
				has = 1'b1;
				r   = '{KIND_REPORT, 8'h00, 8'h00, 11'd0, STATUS_TOO_SHORT};
				parser_hunt();
			end else if (p_len > DF_MAX_LEN) begin
				has = 1'b1;
				r   = '{KIND_REPORT, 8'h00, 8'h00, 11'd0, STATUS_TOO_LONG};
				parser_hunt();
			end else begin
				p_count = 11'(HEADER_BYTES);
			end
		end else if (p_count == HEADER_BYTES) begin
			p_cmd   = b;
			p_sum   = p_sum + b;
			p_count = 11'(HEADER_BYTES + 1);
		end else if (int'(p_count) < int'(p_len) + 2) begin
			// payload byte
			p_sum   = p_sum + b;
			p_count = p_count + 11'd1;
			has     = 1'b1;
			r       = '{KIND_PAYLOAD, b, p_cmd, 11'(p_len - 16'd2), STATUS_OK};
		end else begin
			// checksum byte closes the frame
			has = 1'b1;
			r   = '{KIND_REPORT, 8'h00, p_cmd, 11'(p_len - 16'd2),
				(b == p_sum) ? STATUS_OK : STATUS_BAD_SUM};
			parser_hunt();
		end
	endtask

	task automatic push_byte(input logic [7:0] b, input bit counted);
		rx_item_t it;
		it       = '0;
		it.b     = b;
		it.hold  = hold_next;
		hold_next = 1'b0;
		byte_q.push_back(it);
		if (counted)
			frame_bytes++;
	endtask

	// one frame for the current sync value; length errors stop after the header
	task automatic add_frame(input int len, input bit good);
		logic [15:0] lf;
		logic [7:0]  sum;
		logic [7:0]  b;
		lf  = len[15:0];
		sum = p_sync + lf[15:8] + lf[7:0];
		push_byte(p_sync, 1'b1);
		push_byte(lf[15:8], 1'b1);
		push_byte(lf[7:0], 1'b1);
		if (lf < MIN_LEN || lf > DF_MAX_LEN)
			return;
		// command and payload
		for (int k = 0; k < len - 1; k++) begin
			b   = 8'($urandom_range(0, 255));
			sum = sum + b;
			push_byte(b, 1'b1);
		end
		if (!good)
			sum = sum + 8'($urandom_range(1, 255));
		push_byte(sum, 1'b1);
	endtask

	task automatic add_random_frames(input int n);
		int start;
		int r;
		start = frame_bytes;
		while (frame_bytes - start < n) begin
			r = $urandom_range(0, 99);
			if (r < 10) begin
				repeat ($urandom_range(1, 3)) push_byte(8'($urandom_range(0, 255)), 1'b0);
			end else if (r < 17) begin
				add_frame($urandom_range(0, 1), 1'b1);
			end else if (r < 24) begin
				add_frame($urandom_range(DF_MAX_LEN + 1, 65535), 1'b1);
			end else if (r < 28) begin
				add_frame($urandom_range(25, 200), $urandom_range(0, 99) < 85);
			end else begin
				add_frame($urandom_range(2, 20), $urandom_range(0, 99) < 85);
			end
		end
	endtask

	// every queued byte sent, every expected result seen, pipeline empty
	task automatic wait_drained();
		do @(negedge clk);
		while (byte_q.size() != 0 || in_valid || pending_results.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr[2] == REG_SYNC_BYTE)
			p_sync = data[7:0];
	endtask

	task automatic check_sync_readback();
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= SYNC_ADDR;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk);
		while (!pready);
		if (prdata[7:0] !== p_sync) begin
			$error("sync_byte readback: expected %0h, got %0h", p_sync, prdata[7:0]);
			fails++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic check_field(input string name, input logic [10:0] want, input logic [10:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fails++;
		end
	endtask

	// input channel: hold a byte until accepted, then maybe idle at random;
	// a hold mark makes the byte wait until all outstanding results are in
	always @(posedge clk) begin : sender
		rx_item_t cur;
		bit       has;
		result_t  predicted;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				cur = byte_q.pop_front();
				deframe_step(cur.b, has, predicted);
				n_bytes++;
				if (cur.typed)
					pending_results.push_back(cur.res);
				else if (has)
					pending_results.push_back(predicted);
			end
			if (in_valid && !in_ready) begin
				// transaction still pending, payload stays put
			end else if (byte_q.size() != 0
					&& !(byte_q[0].hold && pending_results.size() != 0)
					&& $urandom_range(0, 99) >= tx_idle) begin
				in_valid <= 1'b1;
				rx_byte  <= byte_q[0].b;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output channel: random stalls, in-order compare against the oldest expectation
	always @(posedge clk) begin : receiver
		result_t want;
		if (arst_n) begin
			out_ready <= ($urandom_range(0, 99) >= rx_idle);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result transaction with nothing expected: kind %0d status %0d",
						result_kind, frame_status);
					fails++;
				end else begin
					want = pending_results.pop_front();
					check_field("result_kind", 11'(want.kind), 11'(result_kind));
					check_field("payload_byte", 11'(want.data), 11'(payload_byte));
					check_field("command_id", 11'(want.cmd), 11'(command_id));
					check_field("payload_length", want.plen, payload_length);
					check_field("frame_status", 11'(want.status), 11'(frame_status));
					if (want.kind == KIND_PAYLOAD)
						n_payload++;
					else begin
						n_report++;
						status_seen[want.status]++;
					end
				end
			end
		end
	end

	always @(posedge clk) begin : watchdog
		cycles = cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	initial begin : main
		rx_item_t it;
		p_sync = SYNC_RESET;
		parser_hunt();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		// directed table with the reset sync value
		tx_idle = 27;
		rx_idle = 49;
		check_sync_readback();
		for (int i = 0; i < $size(DIRECTED); i++) begin
			it       = '0;
			it.b     = DIRECTED[i].b;
			it.typed = DIRECTED[i].typed;
			it.res   = '{KIND_REPORT, 8'h00, 8'h00, 11'd0, DIRECTED[i].status};
			byte_q.push_back(it);
		end
		wait_drained();

		// sync 0x00; a write to the unused index must leave it alone
		apb_write(SYNC_ADDR, 32'h0000_0000);
		apb_write(SPARE_ADDR, 32'hffff_ffff);
		check_sync_readback();
		add_random_frames(120);
		// sender waits for the backlog to clear before this frame
		hold_next = 1'b1;
		add_frame($urandom_range(2, 20), 1'b1);
		add_random_frames(120);
		wait_drained();

		// sync 0xff, idling swapped
		tx_idle = 49;
		rx_idle = 27;
		apb_write(SYNC_ADDR, 32'hffff_ffff);
		check_sync_readback();
		add_random_frames(260);
		wait_drained();

		// random sync, no idling
		tx_idle = 0;
		rx_idle = 0;
		apb_write(SYNC_ADDR, $urandom_range(0, 255));
		check_sync_readback();
		add_random_frames(130);
		add_random_frames(130);
		wait_drained();

		$display("run covered %0d bytes in, %0d payload bytes and %0d frame reports out",
			n_bytes, n_payload, n_report);
		$display("reports by status: ok %0d, bad sum %0d, too short %0d, too long %0d",
			status_seen[STATUS_OK], status_seen[STATUS_BAD_SUM],
			status_seen[STATUS_TOO_SHORT], status_seen[STATUS_TOO_LONG]);
		if (fails == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
